// ===== hw/rtl/pbbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power button and battery supervisor package
// Shared payload types, configuration layout, codes and the report divider.
// ----------------------------------------------------------------------------
package pbbs_pkg;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int SAMPLE_BITS_MAX = 16;
	localparam int ADC_W           = 12;
	localparam int THR_W           = 12;
	localparam int DEB_W           = 8;
	localparam int TMR_W           = 16;
	localparam int CFG_DATA_W      = 16;
	localparam int CFG_IDX_W       = 3;

	// Item kinds.
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_PRESS = 2'd1;
	localparam logic [1:0] KIND_ADC   = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AUTOOFF      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PER   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_SAMPLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_THR      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR     = 3'd5;

	// Reset values.
	localparam logic [DEB_W-1:0] DEBOUNCE_RST     = 8'd5;
	localparam logic [TMR_W-1:0] AUTOOFF_RST      = 16'd2445;
	localparam logic [TMR_W-1:0] SAMPLE_PER_RST   = 16'd156;
	localparam logic [TMR_W-1:0] FIRST_SAMPLE_RST = 16'd20;
	localparam logic [THR_W-1:0] LOW_THR_RST      = 12'd2800;
	localparam logic [THR_W-1:0] HIGH_THR_RST     = 12'd3300;

	typedef struct packed {
		logic [1:0]       kind;
		logic [ADC_W-1:0] adc_value;
	} item_t;

	typedef struct packed {
		logic       regulator_on;
		logic       start_sample;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       battery_ok;
		logic       button_armed;
	} result_t;

	typedef struct packed {
		logic [DEB_W-1:0] debounce_ticks;
		logic [TMR_W-1:0] autooff_ticks;
		logic [TMR_W-1:0] sample_period_ticks;
		logic [TMR_W-1:0] first_sample_delay;
		logic [THR_W-1:0] low_threshold;
		logic [THR_W-1:0] high_threshold;
	} cfg_t;

	// x / 20, saturated to one byte. Computed as (x / 4) / 5, where the
	// division by five is a multiply by 52429 and a shift by 18, exact for
	// any 14-bit operand.
	function automatic logic [7:0] div20_sat(input logic [SAMPLE_BITS_MAX-1:0] x);
		logic [SAMPLE_BITS_MAX-3:0] quarter;
		logic [29:0]                prod;
		logic [11:0]                quo;
		quarter = x[SAMPLE_BITS_MAX-1:2];
		prod    = 30'(quarter) * 30'd52429;
		quo     = prod[29:18];
		return (quo > 12'd255) ? 8'd255 : quo[7:0];
	endfunction

endpackage

// ===== hw/rtl/power_button_battery_supervisor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power button and battery supervisor
// Regulator enable control from ticks, button presses and battery samples.
// ----------------------------------------------------------------------------
//   Channel   Signals                          Moves
//   item      item_valid, item_stall, item     one tick, press or ADC result
//   result    result_valid, result_stall, ...  one status word per item
//   config    cfg_we, cfg_index, cfg_data      register write, no read-back
//
// One item per clock is accepted while item_stall is low. An item lands in
// the input register, and the state update then writes its result register.
// Reset clears all state and loads the register defaults.
// When the result register is full and stalled, item_stall rises in the same
// cycle the input register cannot drain.
// ----------------------------------------------------------------------------
module power_button_battery_supervisor #(
	parameter int SAMPLE_BITS = pbbs_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  pbbs_pkg::item_t                 item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output pbbs_pkg::result_t               result,
	input  logic                            cfg_we,
	input  logic [pbbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pbbs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pbbs_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_next;
	result_t res_q;
	logic    res_valid_q;
	logic    advance;
	logic    take;

	assign advance    = valid_s1 && (!res_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign take       = item_valid && !item_stall;

	pbbs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pbbs_state #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// ===== hw/rtl/pbbs_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Supervisor configuration registers
// Write-only register file holding the timer loads and battery thresholds.
// ----------------------------------------------------------------------------
module pbbs_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pbbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pbbs_pkg::CFG_DATA_W-1:0] cfg_data,
	output pbbs_pkg::cfg_t                 cfg
);
	import pbbs_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks      <= DEBOUNCE_RST;
			cfg_q.autooff_ticks       <= AUTOOFF_RST;
			cfg_q.sample_period_ticks <= SAMPLE_PER_RST;
			cfg_q.first_sample_delay  <= FIRST_SAMPLE_RST;
			cfg_q.low_threshold       <= LOW_THR_RST;
			cfg_q.high_threshold      <= HIGH_THR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE:     cfg_q.debounce_ticks      <= cfg_data[DEB_W-1:0];
				REG_AUTOOFF:      cfg_q.autooff_ticks       <= cfg_data[TMR_W-1:0];
				REG_SAMPLE_PER:   cfg_q.sample_period_ticks <= cfg_data[TMR_W-1:0];
				REG_FIRST_SAMPLE: cfg_q.first_sample_delay  <= cfg_data[TMR_W-1:0];
				REG_LOW_THR:      cfg_q.low_threshold       <= cfg_data[THR_W-1:0];
				REG_HIGH_THR:     cfg_q.high_threshold      <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/pbbs_state.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Supervisor state update
// Holds the power, debounce, timer and battery state and computes the result
// of one item in a single pass.
// ----------------------------------------------------------------------------
module pbbs_state #(
	parameter int SAMPLE_BITS = pbbs_pkg::SAMPLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  pbbs_pkg::item_t   item,
	input  pbbs_pkg::cfg_t    cfg,
	output pbbs_pkg::result_t result
);
	import pbbs_pkg::*;

	localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

	logic                   power_q, power_n;
	logic                   busy_q, busy_n;
	logic [DEB_W-1:0]       deb_q, deb_n;
	logic [TMR_W-1:0]       cnt_q, cnt_n;
	logic [TMR_W-1:0]       aoff_q, aoff_n;
	logic                   good_q, good_n;
	logic [SAMPLE_BITS-1:0] latest_q, latest_n;
	logic [SAMPLE_BITS-1:0] held_q, held_n;
	logic                   req;

	always_comb begin
		power_n  = power_q;
		busy_n   = busy_q;
		deb_n    = deb_q;
		cnt_n    = cnt_q;
		aoff_n   = aoff_q;
		good_n   = good_q;
		latest_n = latest_q;
		held_n   = held_q;
		req      = 1'b0;

		case (item.kind)
			KIND_TICK: begin
				if (busy_q) begin
					deb_n = deb_q - 1'b1;
					if (deb_n == '0) busy_n = 1'b0;
				end
				if (aoff_q != '0) begin
					aoff_n = aoff_q - 1'b1;
					if (aoff_n == '0) power_n = 1'b0;
				end
				if (power_n) begin
					if (cnt_q == '0) begin
						cnt_n  = cfg.sample_period_ticks;
						held_n = latest_q;
						req    = 1'b1;
					end
					cnt_n = cnt_n - 1'b1;
					// The check runs on the held sample even when nothing new was taken.
					if (good_q) begin
						if (CMP_W'(held_n) < CMP_W'(cfg.low_threshold)) begin
							good_n  = 1'b0;
							aoff_n  = '0;
							power_n = 1'b0;
						end
					end else if (CMP_W'(held_n) > CMP_W'(cfg.high_threshold)) begin
						good_n = 1'b1;
					end
				end
			end
			KIND_PRESS: begin
				if (!busy_q) begin
					deb_n   = cfg.debounce_ticks;
					busy_n  = 1'b1;
					power_n = !power_q;
					if (!power_q) begin
						cnt_n  = cfg.first_sample_delay;
						aoff_n = cfg.autooff_ticks;
					end
				end
			end
			KIND_ADC: latest_n = SAMPLE_BITS'(item.adc_value);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_q  <= 1'b0;
			busy_q   <= 1'b0;
			deb_q    <= DEBOUNCE_RST;
			cnt_q    <= FIRST_SAMPLE_RST;
			aoff_q   <= '0;
			good_q   <= 1'b1;
			latest_q <= '1;
			held_q   <= '1;
		end else if (step) begin
			power_q  <= power_n;
			busy_q   <= busy_n;
			deb_q    <= deb_n;
			cnt_q    <= cnt_n;
			aoff_q   <= aoff_n;
			good_q   <= good_n;
			latest_q <= latest_n;
			held_q   <= held_n;
		end
	end

	always_comb begin
		result.regulator_on = power_n;
		result.start_sample = req;
		result.tx_valid     = req;
		result.tx_byte      = req ? div20_sat(SAMPLE_BITS_MAX'(held_n)) : 8'd0;
		result.battery_ok   = good_n;
		result.button_armed = !busy_n;
	end

endmodule

// ===== hw/rtl/pbbs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Supervisor port checker
// Watches the result channel of the supervisor and is bound to its top level.
// ----------------------------------------------------------------------------
module pbbs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_stall,
	input pbbs_pkg::result_t result
);
	import pbbs_pkg::*;

	// A report byte always goes out together with a conversion request.
	a_tx_with_request: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.tx_valid == result.start_sample))
		else $error("report byte without matching conversion request");

	// The byte field is zero on every transfer that carries no report.
	a_byte_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.tx_valid) |-> (result.tx_byte == 8'd0))
		else $error("report byte nonzero without a report");

	// A stalled result stays put.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result)))
		else $error("stalled result changed or dropped");

endmodule

bind power_button_battery_supervisor pbbs_checker u_pbbs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power button and battery supervisor testbench
// Drives ticks, presses and ADC results through the item channel under random
// bursts and receiver stalls. A scoreboard tracks the regulator, debounce,
// auto-off, sample and battery state and checks every status transfer.
// ----------------------------------------------------------------------------
module tb_top;
	import pbbs_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int LONG_HOLD      = 64;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_PRINTED    = 30;

	// Tracks the supervisor state and keeps the expected status words in order.
	class status_scoreboard;
		cfg_t        cfg;
		logic        pwr;
		logic        busy;
		logic        bat_good;
		logic [7:0]  deb_left;
		logic [15:0] countdown;
		logic [15:0] autooff_left;
		logic [11:0] latest;
		logic [11:0] held;
		result_t     expected_status[$];
		int          errors;
		int          n_items;
		int          n_checked;
		int          n_reports;
		int          n_cutoffs;
		int          n_toggles;
		int          n_timeouts;

		function new();
			cfg = '{DEBOUNCE_RST, AUTOOFF_RST, SAMPLE_PER_RST, FIRST_SAMPLE_RST,
				LOW_THR_RST, HIGH_THR_RST};
			pwr = 1'b0;
			busy = 1'b0;
			bat_good = 1'b1;
			deb_left = 8'd5;
			countdown = 16'd20;
			autooff_left = 16'd0;
			latest = 12'hFFF;
			held = 12'hFFF;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_DEBOUNCE:     cfg.debounce_ticks = data[DEB_W-1:0];
			REG_AUTOOFF:      cfg.autooff_ticks = data;
			REG_SAMPLE_PER:   cfg.sample_period_ticks = data;
			REG_FIRST_SAMPLE: cfg.first_sample_delay = data;
			REG_LOW_THR:      cfg.low_threshold = data[THR_W-1:0];
			REG_HIGH_THR:     cfg.high_threshold = data[THR_W-1:0];
			default: ;
			endcase
		endfunction

		function int pending();
			return expected_status.size();
		endfunction

		function void note_item(item_t it);
			result_t r;
			logic    req;
			req = 1'b0;
			n_items++;
			case (it.kind)
			KIND_TICK: begin
				if (busy) begin
					deb_left = deb_left - 8'd1;
					if (deb_left == 8'd0)
						busy = 1'b0;
				end
				// The auto-off timer keeps running even after a press turned
				// the regulator off; expiring then only rewrites off.
				if (autooff_left != 16'd0) begin
					autooff_left = autooff_left - 16'd1;
					if (autooff_left == 16'd0) begin
						if (pwr)
							n_timeouts++;
						pwr = 1'b0;
					end
				end
				if (pwr) begin
					if (countdown == 16'd0) begin
						countdown = cfg.sample_period_ticks;
						held = latest;
						req = 1'b1;
					end
					countdown = countdown - 16'd1;
					if (bat_good) begin
						if (held < cfg.low_threshold) begin
							bat_good = 1'b0;
							autooff_left = 16'd0;
							pwr = 1'b0;
							n_cutoffs++;
						end
					end else if (held > cfg.high_threshold) begin
						bat_good = 1'b1;
					end
				end
			end
			KIND_PRESS: begin
				if (!busy) begin
					deb_left = cfg.debounce_ticks;
					busy = 1'b1;
					pwr = !pwr;
					n_toggles++;
					if (pwr) begin
						countdown = cfg.first_sample_delay;
						autooff_left = cfg.autooff_ticks;
					end
				end
			end
			KIND_ADC: latest = it.adc_value;
			default: ;
			endcase
			if (req)
				n_reports++;
			r.regulator_on = pwr;
			r.start_sample = req;
			r.tx_valid = req;
			r.tx_byte = req ? 8'(held / 20) : 8'd0;
			r.battery_ok = bat_good;
			r.button_armed = !busy;
			expected_status.push_back(r);
		endfunction

		task report(string msg);
			if (errors < MAX_PRINTED)
				$display("ERROR %0t: %s", $time, msg);
			errors++;
		endtask

		task check_status(result_t got);
			result_t exp;
			if (expected_status.size() == 0) begin
				report("status transfer with nothing expected");
			end else begin
				exp = expected_status.pop_front();
				if (got.regulator_on !== exp.regulator_on)
					report($sformatf("status %0d: regulator_on %b, expected %b",
						n_checked, got.regulator_on, exp.regulator_on));
				if (got.start_sample !== exp.start_sample)
					report($sformatf("status %0d: start_sample %b, expected %b",
						n_checked, got.start_sample, exp.start_sample));
				if (got.tx_valid !== exp.tx_valid)
					report($sformatf("status %0d: tx_valid %b, expected %b",
						n_checked, got.tx_valid, exp.tx_valid));
				if (got.tx_byte !== exp.tx_byte)
					report($sformatf("status %0d: tx_byte %0d, expected %0d",
						n_checked, got.tx_byte, exp.tx_byte));
				if (got.battery_ok !== exp.battery_ok)
					report($sformatf("status %0d: battery_ok %b, expected %b",
						n_checked, got.battery_ok, exp.battery_ok));
				if (got.button_armed !== exp.button_armed)
					report($sformatf("status %0d: button_armed %b, expected %b",
						n_checked, got.button_armed, exp.button_armed));
			end
			n_checked++;
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	item_t                 item_bus = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result_bus;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	status_scoreboard sb;
	int hold_requests = 0;
	int holds_done = 0;
	int hold_left = 0;
	int stall_mode = 0;
	int stall_mode_left = 0;
	int idle_cycles = 0;

	power_button_battery_supervisor u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item_bus),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_bus),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial sb = new();

	// Status monitor: every accepted transfer is checked against the oldest
	// expectation.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_status(result_bus);
	end

	// Receiver stall pattern: stretches of a random mode, plus a long hold on
	// request that lets the block fill up and push back on its input.
	always @(posedge clk) begin
		if (holds_done != hold_requests) begin
			holds_done = hold_requests;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			if (stall_mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_mode_left = $urandom_range(16, 96);
			end
			stall_mode_left--;
			case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			2: result_stall <= ($urandom_range(0, 3) != 0);
			default: result_stall <= ~result_stall;
			endcase
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic item_t make_item(logic [1:0] kind, logic [11:0] adc);
		item_t it;
		it.kind = kind;
		it.adc_value = adc;
		return it;
	endfunction

	// Samples cluster around the current thresholds so that the hysteresis
	// is crossed in both directions.
	function automatic logic [11:0] pick_sample();
		int base;
		case ($urandom_range(0, 7))
		0: return 12'd0;
		1: return 12'hFFF;
		2, 3: return 12'($urandom);
		4, 5: base = int'(sb.cfg.low_threshold);
		default: base = int'(sb.cfg.high_threshold);
		endcase
		base = base + int'($urandom_range(0, 64)) - 32;
		if (base < 0)
			base = 0;
		if (base > 4095)
			base = 4095;
		return 12'(base);
	endfunction

	function automatic item_t random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 68)
			return make_item(KIND_TICK, 12'($urandom));
		else if (r < 82)
			return make_item(KIND_ADC, pick_sample());
		else if (r < 94)
			return make_item(KIND_PRESS, 12'($urandom));
		return make_item(KIND_UNUSED, 12'($urandom));
	endfunction

	task automatic send_item(item_t it);
		item_bus <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sb.note_item(it);
	endtask

	task automatic idle_input(int n);
		if (n > 0) begin
			item_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Every item yields one status word, so an empty queue means the block
	// is idle; a further wait afterwards covers the two-stage pipeline.
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic configure(logic [7:0] deb, logic [15:0] aoff, logic [15:0] per,
			logic [15:0] first, logic [11:0] lo, logic [11:0] hi);
		write_reg(REG_DEBOUNCE, 16'(deb));
		write_reg(REG_AUTOOFF, aoff);
		write_reg(REG_SAMPLE_PER, per);
		write_reg(REG_FIRST_SAMPLE, first);
		write_reg(REG_LOW_THR, 16'(lo));
		write_reg(REG_HIGH_THR, 16'(hi));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(int count, bit long_hold);
		int left;
		int burst;
		left = count;
		if (long_hold)
			hold_requests++;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			if (burst > left)
				burst = left;
			repeat (burst) send_item(random_item());
			left -= burst;
			idle_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
		end
		drain();
	endtask

	task automatic random_small_config();
		logic [11:0] lo;
		lo = 12'($urandom_range(0, 4095));
		configure(8'($urandom_range(0, 4)),
			($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 120)),
			16'($urandom_range(0, 10)), 16'($urandom_range(0, 10)),
			lo, 12'($urandom_range(lo, 4095)));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Short timers so that every path shows up within a few items.
		configure(8'd1, 16'd3, 16'd1, 16'd0, 12'd2800, 12'd3300);
		send_item(make_item(KIND_UNUSED, 12'hFFF));
		send_item(make_item(KIND_ADC, 12'hFFF));
		send_item(make_item(KIND_PRESS, 12'd0));
		send_item(make_item(KIND_PRESS, 12'hFFF));
		send_item(make_item(KIND_TICK, 12'd0));
		send_item(make_item(KIND_ADC, 12'd0));
		send_item(make_item(KIND_TICK, 12'hFFF));
		send_item(make_item(KIND_ADC, 12'hFFF));
		send_item(make_item(KIND_PRESS, 12'd0));
		send_item(make_item(KIND_TICK, 12'd0));
		send_item(make_item(KIND_TICK, 12'd0));
		send_item(make_item(KIND_TICK, 12'd0));
		send_item(make_item(KIND_TICK, 12'd0));
		send_item(make_item(KIND_PRESS, 12'd0));
		send_item(make_item(KIND_PRESS, 12'd0));
		send_item(make_item(KIND_TICK, 12'd0));
		send_item(make_item(KIND_PRESS, 12'd0));
		repeat (4) send_item(make_item(KIND_TICK, 12'hFFF));
		send_item(make_item(KIND_ADC, 12'h800));
		send_item(make_item(KIND_ADC, 12'h7FF));
		send_item(make_item(KIND_UNUSED, 12'd0));
		drain();

		configure(DEBOUNCE_RST, AUTOOFF_RST, SAMPLE_PER_RST, FIRST_SAMPLE_RST,
			LOW_THR_RST, HIGH_THR_RST);
		run_phase(300, 1'b0);
		configure(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'd0, 12'hFFF);
		run_phase(150, 1'b0);
		// Zero debounce locks the button for a full wrap of its counter.
		configure(8'd0, 16'd0, 16'd0, 16'd0, 12'd0, 12'd0);
		run_phase(200, 1'b0);
		repeat (4) begin
			random_small_config();
			run_phase(250, holds_done == 0);
		end

		$display("Ran %0d items: %0d report bytes, %0d regulator toggles, %0d cutoffs,",
			sb.n_items, sb.n_reports, sb.n_toggles, sb.n_cutoffs);
		$display("%0d auto-off expiries, %0d long receiver holds, %0d mismatches",
			sb.n_timeouts, holds_done, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
